@@ rtl/core/mos_pkg.sv @@
// shared types and codes for the median-of-two-sorted-lists block
// no dependencies; imported by mos_walk, median_of_two_sorted_arrays, median_checker and tb_top
package mos_pkg;

   // action codes carried on the request tuser
   localparam logic [1:0] ACT_LOAD_FIRST  = 2'd0;
   localparam logic [1:0] ACT_LOAD_SECOND = 2'd1;
   localparam logic [1:0] ACT_COMPUTE     = 2'd2;

   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned MEDIAN_W = 33;

   // walk sequencer states
   typedef enum logic [1:0] {
      WALK_IDLE,
      WALK_STEP,
      WALK_DONE
   } walk_state_type;

   // finished result handed from the walker to the output register
   typedef struct packed {
      logic                       valid;
      logic signed [MEDIAN_W-1:0] median;
      logic                       empty;
   } walk_result_type;

endpackage

@@ rtl/core/median_of_two_sorted_arrays.sv @@
// top level: load control, two list stores, walk sequencer, result register
// depends on mos_pkg, mos_list_mem and mos_walk
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-------------------------------------
//  req     | in  | req_tvalid/req_tready | tdata: value; tuser: action
//  rsp     | out | rsp_tvalid/rsp_tready | tdata: median_doubled; tuser: flags
//
// loads transfer back to back while the block is idle
// a compute walks one merged element per cycle through the shared compare
// unit, then hands the finished result over to the result register
// reset clears counts, dropped flag and the result valid; stores keep data
// a waiting result does not block loads; a compute holds until it can deliver
module median_of_two_sorted_arrays #(
   parameter int unsigned LIST_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [1:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [32:0] median_doubled, [39:33] zero
   output logic [1:0]  rsp_tuser    // [0] empty_res, [1] overflowed
);
   import mos_pkg::*;

   localparam int unsigned CNT_W  = $clog2(LIST_DEPTH + 1);
   localparam int unsigned ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

   logic [CNT_W-1:0]   first_count_ff, first_count_in;
   logic [CNT_W-1:0]   second_count_ff, second_count_in;
   logic               dropped_ff, dropped_in;
   logic               ovf_hold_ff, ovf_hold_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [MEDIAN_W-1:0] rsp_median_ff;
   logic               rsp_empty_ff, rsp_ovf_ff;

   logic               req_xfer;
   logic               first_full, second_full;
   logic               wr_first, wr_second, start;
   logic               walk_idle, out_free;
   logic [ADDR_W-1:0]  first_rd_addr, second_rd_addr;
   logic [31:0]        first_rd_data, second_rd_data;
   walk_result_type    walk_result;

   assign req_tready  = walk_idle;
   assign req_xfer    = req_tvalid && req_tready;
   assign first_full  = (first_count_ff == CNT_W'(LIST_DEPTH));
   assign second_full = (second_count_ff == CNT_W'(LIST_DEPTH));
   assign out_free    = !rsp_valid_ff || rsp_tready;

   // load and compute decode
   always_comb begin
      wr_first        = 1'b0;
      wr_second       = 1'b0;
      start           = 1'b0;
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      dropped_in      = dropped_ff;
      ovf_hold_in     = ovf_hold_ff;
      if (req_xfer) begin
         unique case (req_tuser)
            ACT_LOAD_FIRST: begin
               if (first_full) begin
                  dropped_in = 1'b1;
               end else begin
                  wr_first       = 1'b1;
                  first_count_in = first_count_ff + 1'b1;
               end
            end
            ACT_LOAD_SECOND: begin
               if (second_full) begin
                  dropped_in = 1'b1;
               end else begin
                  wr_second       = 1'b1;
                  second_count_in = second_count_ff + 1'b1;
               end
            end
            ACT_COMPUTE: begin
               start           = 1'b1;
               ovf_hold_in     = dropped_ff;
               first_count_in  = '0;
               second_count_in = '0;
               dropped_in      = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // list stores
   mos_list_mem #(
      .DEPTH  (LIST_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_first_mem (
      .clock   (clock),
      .wr_en   (wr_first),
      .wr_addr (first_count_ff[ADDR_W-1:0]),
      .wr_data (req_tdata),
      .rd_addr (first_rd_addr),
      .rd_data (first_rd_data)
   );

   mos_list_mem #(
      .DEPTH  (LIST_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_second_mem (
      .clock   (clock),
      .wr_en   (wr_second),
      .wr_addr (second_count_ff[ADDR_W-1:0]),
      .wr_data (req_tdata),
      .rd_addr (second_rd_addr),
      .rd_data (second_rd_data)
   );

   // walk sequencer
   mos_walk #(
      .CNT_W  (CNT_W),
      .ADDR_W (ADDR_W)
   ) u_walk (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .first_count  (first_count_ff),
      .second_count (second_count_ff),
      .out_free     (out_free),
      .first_data   ($signed(first_rd_data)),
      .second_data  ($signed(second_rd_data)),
      .first_addr   (first_rd_addr),
      .second_addr  (second_rd_addr),
      .idle         (walk_idle),
      .result       (walk_result)
   );

   // result register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (walk_result.valid && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_count_ff  <= '0;
         second_count_ff <= '0;
         dropped_ff      <= 1'b0;
         ovf_hold_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         dropped_ff      <= dropped_in;
         ovf_hold_ff     <= ovf_hold_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (walk_result.valid && out_free) begin
         rsp_median_ff <= walk_result.median;
         rsp_empty_ff  <= walk_result.empty;
         rsp_ovf_ff    <= ovf_hold_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_median_ff};
   assign rsp_tuser  = {rsp_ovf_ff, rsp_empty_ff};

`ifndef SYNTHESIS
   // a compute clears both counts and the dropped flag
   a_compute_clears: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_tuser == ACT_COMPUTE) |=>
         (first_count_ff == '0 && second_count_ff == '0 && !dropped_ff))
      else $error("counts not cleared after compute");

   // counts stay within the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (first_count_ff <= CNT_W'(LIST_DEPTH)) && (second_count_ff <= CNT_W'(LIST_DEPTH)))
      else $error("list count beyond depth");

   // an empty result always carries a zero median
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[32:0] == '0))
      else $error("empty result with nonzero median");

   // the block never takes requests while a walk is in flight
   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_tuser == ACT_COMPUTE) |=> !req_tready)
      else $error("request taken during walk");
`endif

endmodule

@@ rtl/core/mos_list_mem.sv @@
// one list store: single write port, single read port with registered data
// no package dependency; instantiated twice by median_of_two_sorted_arrays
module mos_list_mem #(
   parameter int unsigned DEPTH  = 1024,
   parameter int unsigned ADDR_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [31:0]       wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [31:0]       rd_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/mos_walk.sv @@
// two-pointer walk sequencer with one shared signed compare unit
// depends on mos_pkg; drives the read addresses of both list stores
module mos_walk #(
   parameter int unsigned CNT_W  = 11,
   parameter int unsigned ADDR_W = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [CNT_W-1:0]             first_count,
   input  logic [CNT_W-1:0]             second_count,
   input  logic                         out_free,
   input  logic signed [31:0]           first_data,
   input  logic signed [31:0]           second_data,
   output logic [ADDR_W-1:0]            first_addr,
   output logic [ADDR_W-1:0]            second_addr,
   output logic                         idle,
   output mos_pkg::walk_result_type     result
);
   import mos_pkg::*;

   walk_state_type state_ff, state_in;

   logic [CNT_W-1:0]   i_ff, i_in;
   logic [CNT_W-1:0]   j_ff, j_in;
   logic [CNT_W-1:0]   k_ff, k_in;
   logic [CNT_W-1:0]   na_ff, nb_ff, target_ff;
   logic               odd_ff, empty_ff;
   logic signed [31:0] cur_ff, cur_in, prev_ff, prev_in;

   logic [CNT_W:0]     total;
   logic               take_first;
   logic               last_step;

   assign total     = {1'b0, first_count} + {1'b0, second_count};
   assign last_step = (k_ff == target_ff);

   // shared compare: pick the smaller head, second list on a tie
   always_comb begin
      priority if (i_ff >= na_ff) begin
         take_first = 1'b0;
      end else if (j_ff >= nb_ff) begin
         take_first = 1'b1;
      end else begin
         take_first = first_data < second_data;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         WALK_IDLE: begin
            if (start) begin
               state_in = (total == '0) ? WALK_DONE : WALK_STEP;
            end
         end
         WALK_STEP: begin
            if (last_step) begin
               state_in = WALK_DONE;
            end
         end
         WALK_DONE: begin
            if (out_free) begin
               state_in = WALK_IDLE;
            end
         end
         default: state_in = WALK_IDLE;
      endcase
   end

   // pointer and value updates
   always_comb begin
      i_in    = i_ff;
      j_in    = j_ff;
      k_in    = k_ff;
      cur_in  = cur_ff;
      prev_in = prev_ff;
      unique case (state_ff)
         WALK_IDLE: begin
            i_in    = '0;
            j_in    = '0;
            k_in    = '0;
            cur_in  = '0;
            prev_in = '0;
         end
         WALK_STEP: begin
            prev_in = cur_ff;
            if (take_first) begin
               cur_in = first_data;
               i_in   = i_ff + 1'b1;
            end else begin
               cur_in = second_data;
               j_in   = j_ff + 1'b1;
            end
            k_in = k_ff + 1'b1;
         end
         WALK_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // read addresses follow the next pointers so data is ready each step
   assign first_addr  = i_in[ADDR_W-1:0];
   assign second_addr = j_in[ADDR_W-1:0];
   assign idle        = (state_ff == WALK_IDLE);

   // result: zero when empty, twice the middle for odd totals, sum of middles for even
   always_comb begin
      result.valid  = (state_ff == WALK_DONE);
      result.empty  = empty_ff;
      if (empty_ff) begin
         result.median = '0;
      end else if (odd_ff) begin
         result.median = {cur_ff, 1'b0};
      end else begin
         result.median = {cur_ff[31], cur_ff} + {prev_ff[31], prev_ff};
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= WALK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // walk registers
   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
      cur_ff  <= cur_in;
      prev_ff <= prev_in;
      if (state_ff == WALK_IDLE && start) begin
         na_ff     <= first_count;
         nb_ff     <= second_count;
         target_ff <= total[CNT_W:1];
         odd_ff    <= total[0];
         empty_ff  <= (total == '0);
      end
   end

endmodule

@@ sim/median_checker.sv @@
`timescale 1ns / 100ps
// transfer monitor and scoreboard for median_of_two_sorted_arrays
// mirrors both list stores, predicts every compute result and compares in order
// depends on mos_pkg
module median_checker #(
   parameter int unsigned LIST_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [1:0] action
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // [32:0] median_doubled, [39:33] zero
   input  logic [1:0]  rsp_tuser,   // [0] empty_res, [1] overflowed
   output int          error_count,
   output int          pending_count
);
   import mos_pkg::*;

   typedef struct packed {
      logic signed [MEDIAN_W-1:0] median;
      logic                       empty;
      logic                       dropped;
   } median_expect_type;

   // index 0 is the first list, index 1 the second
   logic [VALUE_W-1:0] list_store [2][LIST_DEPTH];
   int unsigned        list_fill [2];
   bit                 dropped_seen;
   median_expect_type  median_q [$];
   int                 mismatches = 0;

   // two-pointer walk to the middle of the merged order; ties go to the second list
   function automatic logic signed [MEDIAN_W-1:0] walk_median_doubled();
      int unsigned                total;
      int unsigned                pos_a;
      int unsigned                pos_b;
      logic                       take_first;
      logic signed [MEDIAN_W-1:0] prev_val;
      logic signed [MEDIAN_W-1:0] cur_val;
      total    = list_fill[0] + list_fill[1];
      pos_a    = 0;
      pos_b    = 0;
      prev_val = '0;
      cur_val  = '0;
      for (int unsigned k = 0; k <= total / 2; k++) begin
         prev_val = cur_val;
         if (pos_a >= list_fill[0]) begin
            take_first = 1'b0;
         end else if (pos_b >= list_fill[1]) begin
            take_first = 1'b1;
         end else begin
            take_first = $signed(list_store[0][pos_a]) < $signed(list_store[1][pos_b]);
         end
         if (take_first) begin
            cur_val = MEDIAN_W'($signed(list_store[0][pos_a]));
            pos_a++;
         end else begin
            cur_val = MEDIAN_W'($signed(list_store[1][pos_b]));
            pos_b++;
         end
      end
      if (total % 2 != 0)
         return cur_val * 2;
      return cur_val + prev_val;
   endfunction

   always @(posedge clock) begin : watch
      median_expect_type          head;
      logic signed [MEDIAN_W-1:0] got_median;
      int unsigned                side;
      if (reset) begin
         list_fill[0] = 0;
         list_fill[1] = 0;
         dropped_seen = 1'b0;
         median_q.delete();
      end else begin
         // result transfer: compare with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got_median = rsp_tdata[MEDIAN_W-1:0];
            if (median_q.size() == 0) begin
               $error("result with no prediction waiting: median_doubled %0d", got_median);
               mismatches++;
            end else begin
               head = median_q.pop_front();
               if (got_median !== head.median) begin
                  $error("median_doubled: expected %0d, got %0d", head.median, got_median);
                  mismatches++;
               end
               if (rsp_tuser[0] !== head.empty) begin
                  $error("empty_res: expected %0d, got %0d", head.empty, rsp_tuser[0]);
                  mismatches++;
               end
               if (rsp_tuser[1] !== head.dropped) begin
                  $error("overflowed: expected %0d, got %0d", head.dropped, rsp_tuser[1]);
                  mismatches++;
               end
               if (rsp_tdata[39:MEDIAN_W] !== '0) begin
                  $error("tdata padding: expected 0, got %0h", rsp_tdata[39:MEDIAN_W]);
                  mismatches++;
               end
            end
         end
         // request transfer: store a load or predict a compute
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               ACT_LOAD_FIRST, ACT_LOAD_SECOND: begin
                  side = (req_tuser == ACT_LOAD_SECOND) ? 1 : 0;
                  if (list_fill[side] < LIST_DEPTH) begin
                     list_store[side][list_fill[side]] = req_tdata;
                     list_fill[side]++;
                  end else begin
                     dropped_seen = 1'b1;
                  end
               end
               ACT_COMPUTE: begin
                  head.empty   = (list_fill[0] + list_fill[1]) == 0;
                  head.median  = head.empty ? '0 : walk_median_doubled();
                  head.dropped = dropped_seen;
                  median_q.push_back(head);
                  list_fill[0] = 0;
                  list_fill[1] = 0;
                  dropped_seen = 1'b0;
               end
               default: ;  // unused action leaves everything alone
            endcase
         end
      end
      error_count   <= mismatches;
      pending_count <= median_q.size();
   end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// top of the median_of_two_sorted_arrays testbench: clock, reset, stimulus, verdict
// depends on mos_pkg, median_of_two_sorted_arrays and median_checker
module tb_top;
   import mos_pkg::*;

   localparam logic [1:0]  ACT_UNUSED   = 2'd3;
   localparam int          RANDOM_ITEMS = 200;
   localparam int unsigned DEPTH        = 1024;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [31:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = ACT_LOAD_FIRST;
   logic        rsp_tready = 1'b0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   int          error_count;
   int          pending_count;
   int          send_idle_pct = 0;
   int          stall_pct     = 0;
   int          items_sent    = 0;

   median_of_two_sorted_arrays #(.LIST_DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   median_checker #(.LIST_DEPTH(DEPTH)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side backpressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // one request transfer, with random idle cycles ahead of it
   task automatic push_item(input logic [1:0] act, input logic [31:0] val);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= val;
      do @(posedge clock); while (!req_tready);
      if (act != ACT_UNUSED)
         items_sent++;
   endtask

   // style 0 full range, 1 small values with many ties, 2 near the extremes
   function automatic logic [31:0] pick_value(input int unsigned style);
      case (style)
         0:       return $urandom;
         1:       return int'($urandom_range(0, 15)) - 8;
         default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                              : 32'h8000_0000 + $urandom_range(0, 3);
      endcase
   endfunction

   // fill both lists in random interleaving, then ask for the median
   task automatic load_and_compute(input int unsigned n_first, input int unsigned n_second,
                                   input bit sorted, input int unsigned style);
      int first_vals[$];
      int second_vals[$];
      bit pick_second;
      for (int n = 0; n < n_first; n++)
         first_vals.push_back(int'(pick_value(style)));
      for (int n = 0; n < n_second; n++)
         second_vals.push_back(int'(pick_value(style)));
      if (sorted) begin
         first_vals.sort();
         second_vals.sort();
      end
      while (first_vals.size() + second_vals.size() != 0) begin
         if (first_vals.size() == 0)
            pick_second = 1'b1;
         else if (second_vals.size() == 0)
            pick_second = 1'b0;
         else
            pick_second = $urandom_range(0, 1);
         if ($urandom_range(0, 99) < 4)
            push_item(ACT_UNUSED, $urandom);
         if (pick_second)
            push_item(ACT_LOAD_SECOND, second_vals.pop_front());
         else
            push_item(ACT_LOAD_FIRST, first_vals.pop_front());
      end
      push_item(ACT_COMPUTE, $urandom);
   endtask

   initial begin
      int unsigned n_first;
      int unsigned n_second;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty total, unused action, extremes, ties, exhausted and unsorted lists
      push_item(ACT_COMPUTE, 32'hFFFF_FFFF);
      push_item(ACT_UNUSED, 32'h1234_5678);
      push_item(ACT_COMPUTE, 32'h0);
      push_item(ACT_LOAD_FIRST, 32'h7FFF_FFFF);
      push_item(ACT_COMPUTE, 32'h0);
      push_item(ACT_LOAD_FIRST, 32'h8000_0000);
      push_item(ACT_LOAD_SECOND, 32'h8000_0000);
      push_item(ACT_COMPUTE, 32'h0);
      push_item(ACT_LOAD_FIRST, 32'h8000_0000);
      push_item(ACT_LOAD_SECOND, 32'h7FFF_FFFF);
      push_item(ACT_COMPUTE, 32'h0);
      push_item(ACT_LOAD_FIRST, 32'd1);
      push_item(ACT_LOAD_FIRST, 32'd2);
      push_item(ACT_LOAD_FIRST, 32'd3);
      push_item(ACT_LOAD_SECOND, 32'd10);
      push_item(ACT_COMPUTE, 32'h0);
      push_item(ACT_LOAD_FIRST, 32'd5);
      push_item(ACT_LOAD_FIRST, -32'sd3);
      push_item(ACT_LOAD_FIRST, 32'd9);
      push_item(ACT_LOAD_SECOND, 32'd0);
      push_item(ACT_COMPUTE, 32'h0);
      push_item(ACT_LOAD_SECOND, -32'sd7);
      push_item(ACT_LOAD_SECOND, 32'd4);
      push_item(ACT_COMPUTE, 32'h0);

      // full first list with dropped loads, then a compute that must clear the flag
      send_idle_pct = 20;
      stall_pct     = 20;
      load_and_compute(DEPTH + 2, 3, 1'b1, 0);
      load_and_compute(2, 1, 1'b1, 1);

      // random sets through the four idling phases
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         case (items_sent * 4 / RANDOM_ITEMS)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 72; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 72; end
            default: begin send_idle_pct = 20; stall_pct = 20; end
         endcase
         if ($urandom_range(0, 99) < 85) begin
            n_first  = $urandom_range(0, 12);
            n_second = $urandom_range(0, 12);
         end else begin
            n_first  = $urandom_range(0, 40);
            n_second = $urandom_range(0, 40);
         end
         load_and_compute(n_first, n_second, $urandom_range(0, 9) != 0, $urandom_range(0, 2));
      end

      // drain outstanding results, then let the bench idle before the verdict
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (30) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
